[src/ctc_pkg.sv]
// ----------------------------------------------------------------------------
// ctc_pkg
// shared types, result codes and the keyword table of the token classifier
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

    localparam int NUM_KW = 16;

    localparam logic [2:0] KIND_RESERVED = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_VARIABLE = 3'd2;
    localparam logic [2:0] KIND_INTEGER  = 3'd3;
    localparam logic [2:0] KIND_FLOAT    = 3'd4;
    localparam logic [2:0] KIND_STMT_END = 3'd5;
    localparam logic [2:0] KIND_ERROR    = 3'd6;

    localparam logic [3:0] LEN_SAT = 4'd8;
    localparam logic [1:0] DOT_SAT = 2'd2;

    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } char_word_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       last;
    } tok_word_t;

    // up to two result words made by one character
    typedef struct packed {
        logic      push;
        logic      two;
        tok_word_t r0;
        tok_word_t r1;
    } res_pair_t;

    // keyword text, first character in the top byte
    function automatic logic [63:0] kw_word(input logic [3:0] idx);
        logic [63:0] w;
        unique case (idx)
            4'd0:  w = {"const", 24'h0};
            4'd1:  w = {"int", 40'h0};
            4'd2:  w = {"float", 24'h0};
            4'd3:  w = {"double", 16'h0};
            4'd4:  w = {"long", 32'h0};
            4'd5:  w = {"static", 16'h0};
            4'd6:  w = {"void", 32'h0};
            4'd7:  w = {"char", 32'h0};
            4'd8:  w = {"extern", 16'h0};
            4'd9:  w = {"return", 16'h0};
            4'd10: w = {"break", 24'h0};
            4'd11: w = {"enum", 32'h0};
            4'd12: w = {"struct", 16'h0};
            4'd13: w = {"typedef", 8'h0};
            4'd14: w = {"union", 24'h0};
            4'd15: w = {"goto", 32'h0};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] idx);
        logic [3:0] n;
        unique case (idx)
            4'd0, 4'd2, 4'd10, 4'd14:             n = 4'd5;
            4'd1:                                 n = 4'd3;
            4'd3, 4'd5, 4'd8, 4'd9, 4'd12:        n = 4'd6;
            4'd4, 4'd6, 4'd7, 4'd11, 4'd15:       n = 4'd4;
            4'd13:                                n = 4'd7;
            default:                              n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [2:0] pos);
        logic [63:0] w;
        w = kw_word(idx) << {pos, 3'b000};
        return w[63:56];
    endfunction

endpackage

`default_nettype wire

[src/ctc_lexer.sv]
// ----------------------------------------------------------------------------
// ctc_lexer
// token state and the combinational step that classes finished tokens
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_lexer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire ctc_pkg::char_word_t item,
    output ctc_pkg::res_pair_t      res
);

    logic [3:0]  tok_len_reg,  tok_len_next;
    logic [15:0] cand_reg,     cand_next;
    logic [7:0]  first_reg,    first_next;
    logic [7:0]  second_reg,   second_next;
    logic        name_ok_reg,  name_ok_next;
    logic        num_ok_reg,   num_ok_next;
    logic [1:0]  dots_reg,     dots_next;
    logic        tail_reg,     tail_next;
    logic        failed_reg,   failed_next;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // class of the token held in the state registers
    logic [15:0] len_hit;
    logic        is_kw;
    logic        op1;
    logic        op2;
    logic [2:0]  cls;

    always_comb
    begin
        for (int i = 0; i < ctc_pkg::NUM_KW; i++)
        begin
            len_hit[i] = ctc_pkg::kw_len(4'(i)) == tok_len_reg;
        end
        is_kw = |(cand_reg & len_hit);
        op1 = (tok_len_reg == 4'd1) &&
              (first_reg == ctc_pkg::CH_PLUS  || first_reg == ctc_pkg::CH_MINUS ||
               first_reg == ctc_pkg::CH_STAR  || first_reg == ctc_pkg::CH_SLASH ||
               first_reg == ctc_pkg::CH_EQ    || first_reg == ctc_pkg::CH_GT    ||
               first_reg == ctc_pkg::CH_LT);
        op2 = (tok_len_reg == 4'd2) && (second_reg == ctc_pkg::CH_EQ) &&
              (first_reg == ctc_pkg::CH_EQ || first_reg == ctc_pkg::CH_BANG ||
               first_reg == ctc_pkg::CH_GT || first_reg == ctc_pkg::CH_LT);
        if (is_kw)
            cls = ctc_pkg::KIND_RESERVED;
        else if (op1 || op2)
            cls = ctc_pkg::KIND_OPERATOR;
        else if (is_letter(first_reg) || first_reg == ctc_pkg::CH_UNDER)
            cls = name_ok_reg ? ctc_pkg::KIND_VARIABLE : ctc_pkg::KIND_ERROR;
        else if (!num_ok_reg)
            cls = ctc_pkg::KIND_ERROR;
        else if (dots_reg == 2'd0)
            cls = ctc_pkg::KIND_INTEGER;
        else if (dots_reg == 2'd1 && tok_len_reg > 4'd1)
            cls = ctc_pkg::KIND_FLOAT;
        else
            cls = ctc_pkg::KIND_ERROR;
    end

    // step
    logic [7:0]  c;
    logic        is_sp;
    logic        is_semi;
    logic        nonempty;
    logic        fin_err;
    logic        emit_cls;
    logic        emit_extra;
    logic [2:0]  extra_kind;
    logic        clear;
    logic [15:0] keep;

    always_comb
    begin
        c        = item.ch;
        is_sp    = (c == ctc_pkg::CH_SPACE) || (c >= ctc_pkg::CH_TAB && c <= ctc_pkg::CH_CR);
        is_semi  = c == ctc_pkg::CH_SEMI;
        nonempty = tok_len_reg != 4'd0;
        fin_err  = cls == ctc_pkg::KIND_ERROR;

        for (int i = 0; i < ctc_pkg::NUM_KW; i++)
        begin
            keep[i] = (tok_len_reg < ctc_pkg::kw_len(4'(i))) &&
                      (ctc_pkg::kw_char(4'(i), tok_len_reg[2:0]) == c);
        end

        emit_cls   = 1'b0;
        emit_extra = 1'b0;
        extra_kind = ctc_pkg::KIND_STMT_END;
        clear      = 1'b0;

        tok_len_next = tok_len_reg;
        cand_next    = cand_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        name_ok_next = name_ok_reg;
        num_ok_next  = num_ok_reg;
        dots_next    = dots_reg;
        tail_next    = tail_reg;
        failed_next  = failed_reg;

        if (fire && !failed_reg)
        begin
            if (item.end_of_input)
            begin
                emit_cls   = nonempty;
                emit_extra = (!nonempty || !fin_err) && tail_reg;
                extra_kind = ctc_pkg::KIND_ERROR;
                clear      = 1'b1;
                tail_next  = 1'b0;
            end
            else if (is_sp)
            begin
                emit_cls = nonempty;
                clear    = 1'b1;
            end
            else if (is_semi)
            begin
                emit_cls   = nonempty;
                emit_extra = !(nonempty && fin_err);
                clear      = 1'b1;
                tail_next  = 1'b0;
            end
            else
            begin
                cand_next = cand_reg & keep;
                if (tok_len_reg == 4'd0)
                    first_next = c;
                if (tok_len_reg == 4'd1)
                    second_next = c;
                if (nonempty && !(is_letter(c) || is_digit(c) || c == ctc_pkg::CH_UNDER))
                    name_ok_next = 1'b0;
                if (!(is_digit(c) || c == ctc_pkg::CH_DOT))
                    num_ok_next = 1'b0;
                if (c == ctc_pkg::CH_DOT && dots_reg < ctc_pkg::DOT_SAT)
                    dots_next = dots_reg + 2'd1;
                if (tok_len_reg < ctc_pkg::LEN_SAT)
                    tok_len_next = tok_len_reg + 4'd1;
                tail_next = 1'b1;
            end

            if ((emit_cls && fin_err) || (emit_extra && extra_kind == ctc_pkg::KIND_ERROR))
                failed_next = 1'b1;
        end

        if (clear)
        begin
            tok_len_next = '0;
            cand_next    = '1;
            first_next   = '0;
            second_next  = '0;
            name_ok_next = 1'b1;
            num_ok_next  = 1'b1;
            dots_next    = '0;
        end

        res = '0;
        if (emit_cls && emit_extra)
        begin
            res.push    = 1'b1;
            res.two     = 1'b1;
            res.r0.kind = cls;
            res.r1.kind = extra_kind;
            res.r1.last = 1'b1;
        end
        else if (emit_cls)
        begin
            res.push    = 1'b1;
            res.r0.kind = cls;
            res.r0.last = 1'b1;
        end
        else if (emit_extra)
        begin
            res.push    = 1'b1;
            res.r0.kind = extra_kind;
            res.r0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_len_reg <= '0;
            cand_reg    <= '1;
            first_reg   <= '0;
            second_reg  <= '0;
            name_ok_reg <= 1'b1;
            num_ok_reg  <= 1'b1;
            dots_reg    <= '0;
            tail_reg    <= 1'b0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            tok_len_reg <= tok_len_next;
            cand_reg    <= cand_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            name_ok_reg <= name_ok_next;
            num_ok_reg  <= num_ok_next;
            dots_reg    <= dots_next;
            tail_reg    <= tail_next;
            failed_reg  <= failed_next;
        end
    end

`ifndef SYNTHESIS
    a_no_word_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !res.push)
        else $error("word produced after a compile error");

    a_len_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        tok_len_reg <= ctc_pkg::LEN_SAT)
        else $error("token length past saturation");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.push && res.two) |-> (res.r1.last && !res.r0.last))
        else $error("last flag misplaced in a word pair");
`endif

endmodule

`default_nettype wire

[src/ctc_result_fifo.sv]
// ----------------------------------------------------------------------------
// ctc_result_fifo
// two-entry queue of word pairs, drained one word per handshake
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_result_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctc_pkg::res_pair_t  res,
    output logic                     room,
    output logic                     tok_valid,
    input  wire logic                tok_stall,
    output ctc_pkg::tok_word_t       tok_word
);

    ctc_pkg::res_pair_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       sub_reg,    sub_next;
    logic       take;
    logic       pop;

    ctc_pkg::res_pair_t head;

    always_comb
    begin
        head      = entry_reg[rd_ptr_reg];
        room      = count_reg != 2'd2;
        tok_valid = count_reg != 2'd0;
        tok_word  = sub_reg ? head.r1 : head.r0;
        take      = tok_valid && !tok_stall;
        // the entry leaves the queue once its last word is taken
        pop       = take && (sub_reg || !head.two);

        sub_next    = sub_reg;
        if (take)
            sub_next = !pop;
        wr_ptr_next = wr_ptr_reg ^ res.push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, res.push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
            entry_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> room)
        else $error("word pair pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

[src/c_token_classifier.sv]
// path: an accepted character word is held in the character register, and the
//   token words it gives are then written into the result queue
// throughput: one character per cycle while the queue has room; a character that
//   closes a token with a statement end or a trailing error gives two words, which
//   the single output port hands out one at a time
// reset: rst_n clears the token state, the error flag and the queue at once
// ----------------------------------------------------------------------------
// c_token_classifier
// byte-stream lexer that classes tokens as keyword, operator, name or number
// ----------------------------------------------------------------------------
`default_nettype none

module c_token_classifier (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_stall,
    input  wire ctc_pkg::char_word_t char_word,
    output logic                     tok_valid,
    input  wire logic                tok_stall,
    output ctc_pkg::tok_word_t       tok_word
);

    logic                in_valid_reg;
    ctc_pkg::char_word_t in_item_reg;
    logic                room;
    logic                fire;
    ctc_pkg::res_pair_t  res;

    // the step runs whenever a character is held and the queue has room for a full pair
    assign fire       = in_valid_reg && room;
    assign char_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!char_stall)
            in_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            in_item_reg <= char_word;
    end

    ctc_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .res   (res)
    );

    ctc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_word  (tok_word)
    );

endmodule

`default_nettype wire
